[hw/rtl/eps_pkg.sv]
// eps_pkg: shared widths, codes and the restoring divide step for the
// encoder position and speed block
// no dependencies
package eps_pkg;

  localparam int POS_W    = 48;  // accumulated position width
  localparam int CNT_IN_W = 32;  // raw counter width
  localparam int ANGLE_W  = 16;  // angle fraction bits, one turn = 2^ANGLE_W
  localparam int SPEED_W  = 33;  // signed speed width
  localparam int CPR_W    = 17;  // counts_per_rev register width
  localparam int PP_W     = 7;   // pole pair count register width
  localparam int SR_W     = 17;  // sample_rate_hz register width
  localparam int CFG_W    = 17;  // config write data width
  localparam int IDX_W    = 2;   // config register index width

  // radix-4 sequencing: two divide steps per cycle
  localparam int MOD_CYC = POS_W / 2;
  localparam int DIV_CYC = ANGLE_W / 2;
  localparam int SEQ_W   = $clog2(MOD_CYC);

  // configuration register indexes
  localparam logic [IDX_W-1:0] CFG_CPR  = 2'd0;
  localparam logic [IDX_W-1:0] CFG_PP   = 2'd1;
  localparam logic [IDX_W-1:0] CFG_RATE = 2'd2;

  // reset values of the configuration registers
  localparam logic [CPR_W-1:0] CPR_RST  = 17'd4096;
  localparam logic [PP_W-1:0]  PP_RST   = 7'd4;
  localparam logic [SR_W-1:0]  RATE_RST = 17'd1000;

  // input op codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef struct packed {
    logic             q;
    logic [CPR_W-1:0] rem;
  } div_res_t;

  // one restoring step: shift one bit into the remainder, subtract if it fits
  function automatic div_res_t div_step(input logic [CPR_W-1:0] rem,
                                        input logic din,
                                        input logic [CPR_W-1:0] dvsr);
    logic [CPR_W:0]   t;
    logic [CPR_W:0]   d;
    div_res_t         res;
    t = {rem, din};
    d = {1'b0, dvsr};
    if (t >= d) begin
      t = t - d;
      res.q = 1'b1;
    end else begin
      res.q = 1'b0;
    end
    res.rem = t[CPR_W-1:0];
    return res;
  endfunction

endpackage

[hw/rtl/encoder_position_speed.sv]
// encoder_position_speed: encoder position, angle and speed estimator
// uses eps_pkg (widths, codes, divide step)
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | in_op, in_counter_value
//  out_    | output    | out_valid/out_stall| position, mech/elec angle, speeds
//  cfg_    | input     | cfg_we             | cfg_index, cfg_wdata
//
// a sample runs the position, absolute value, remainder, floor fix, angle,
// pole pair and speed states, and no new item transfers until its result is
// in the output register; 24 radix-4 remainder steps over the position, 8
// radix-4 quotient steps for the angle, 7 serial pole pair steps and 17 serial
// steps for both speeds share one sequencer; a clear item goes straight to hand-over
// reset (synchronous, rst_n low) loads the register defaults and clears state
// a stalled result stays in the output register; the next item is taken
// meanwhile and waits for that register only at its own end
module encoder_position_speed (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_op,
  input  logic [eps_pkg::CNT_IN_W-1:0]          in_counter_value,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [eps_pkg::POS_W-1:0]      out_position,
  output logic [eps_pkg::ANGLE_W-1:0]           out_mech_ang,
  output logic [eps_pkg::ANGLE_W-1:0]           out_elec_ang,
  output logic signed [eps_pkg::SPEED_W-1:0]    out_mech_spd,
  output logic signed [eps_pkg::SPEED_W-1:0]    out_elec_spd,
  // configuration
  input  logic                                  cfg_we,
  input  logic [eps_pkg::IDX_W-1:0]             cfg_index,
  input  logic [eps_pkg::CFG_W-1:0]             cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_POS, S_ABS, S_MOD, S_FIX, S_DIV, S_ELEC, S_SPD, S_DONE
  } state_t;

  state_t state_r;

  // configuration registers
  logic [eps_pkg::CPR_W-1:0] cpr_r;
  logic [eps_pkg::PP_W-1:0]  pp_r;
  logic [eps_pkg::SR_W-1:0]  rate_r;

  // persistent tracking state
  logic [eps_pkg::CNT_IN_W-1:0]     last_r;
  logic [eps_pkg::POS_W-1:0]        pos_r;
  logic [eps_pkg::ANGLE_W-1:0]      prev_mech_r;
  logic [eps_pkg::ANGLE_W-1:0]      prev_elec_r;
  logic                             have_r;

  // per item working registers
  logic [eps_pkg::CNT_IN_W:0]       delta_r;   // wrap corrected count change
  logic [eps_pkg::POS_W-1:0]        mag_r;     // |position|, shifted out msb first
  logic                             neg_r;
  logic [eps_pkg::CPR_W-1:0]        rem_r;
  logic [eps_pkg::ANGLE_W-1:0]      q_r;       // mechanical angle quotient
  logic [eps_pkg::ANGLE_W-1:0]      elec_r;
  logic [eps_pkg::PP_W-1:0]         pp_sh_r;
  logic [eps_pkg::SR_W-1:0]         sr_sh_r;
  logic [eps_pkg::SPEED_W-1:0]      ms_r;
  logic [eps_pkg::SPEED_W-1:0]      es_r;
  logic [eps_pkg::SEQ_W-1:0]        seq_r;

  // output register
  logic                             out_valid_r;
  logic [eps_pkg::POS_W-1:0]        out_pos_r;
  logic [eps_pkg::ANGLE_W-1:0]      out_mech_r;
  logic [eps_pkg::ANGLE_W-1:0]      out_elec_r;
  logic [eps_pkg::SPEED_W-1:0]      out_ms_r;
  logic [eps_pkg::SPEED_W-1:0]      out_es_r;

  logic                             in_xfer;
  logic                             out_free;
  logic [eps_pkg::CPR_W-1:0]        cpr_eff;
  logic [eps_pkg::CNT_IN_W-1:0]     cnt_diff;
  logic [eps_pkg::CNT_IN_W:0]       delta_in;
  logic                             din_hi;
  logic                             din_lo;
  eps_pkg::div_res_t                st1;
  eps_pkg::div_res_t                st2;
  logic [eps_pkg::ANGLE_W-1:0]      d_mech;
  logic [eps_pkg::ANGLE_W-1:0]      d_elec;
  logic [eps_pkg::SPEED_W-1:0]      add_mech;
  logic [eps_pkg::SPEED_W-1:0]      add_elec;

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // a zero revolution count behaves as one
  assign cpr_eff = (cpr_r == '0) ? eps_pkg::CPR_W'(1) : cpr_r;

  // count change: the signed 32-bit difference, except that a raw difference
  // of exactly minus half the counter range turns positive when the new value is below the last
  assign cnt_diff = in_counter_value - last_r;
  always_comb begin
    if (cnt_diff == {1'b1, {(eps_pkg::CNT_IN_W-1){1'b0}}} && in_counter_value < last_r) begin
      delta_in = {1'b0, cnt_diff};
    end else begin
      delta_in = {cnt_diff[eps_pkg::CNT_IN_W-1], cnt_diff};
    end
  end

  // shared radix-4 divide unit: remainder pass takes position bits, the
  // angle quotient pass shifts in zeros
  assign din_hi = (state_r == S_MOD) ? mag_r[eps_pkg::POS_W-1] : 1'b0;
  assign din_lo = (state_r == S_MOD) ? mag_r[eps_pkg::POS_W-2] : 1'b0;
  assign st1 = eps_pkg::div_step(rem_r, din_hi, cpr_eff);
  assign st2 = eps_pkg::div_step(st1.rem, din_lo, cpr_eff);

  // wrapped angle changes, zero until a previous sample exists
  assign d_mech = have_r ? (q_r - prev_mech_r) : '0;
  assign d_elec = have_r ? (elec_r - prev_elec_r) : '0;

  // serial multiply by the sample rate, msb first
  assign add_mech = sr_sh_r[eps_pkg::SR_W-1] ?
    {{(eps_pkg::SPEED_W-eps_pkg::ANGLE_W){d_mech[eps_pkg::ANGLE_W-1]}}, d_mech} : '0;
  assign add_elec = sr_sh_r[eps_pkg::SR_W-1] ?
    {{(eps_pkg::SPEED_W-eps_pkg::ANGLE_W){d_elec[eps_pkg::ANGLE_W-1]}}, d_elec} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cpr_r       <= eps_pkg::CPR_RST;
      pp_r        <= eps_pkg::PP_RST;
      rate_r      <= eps_pkg::RATE_RST;
      last_r      <= '0;
      pos_r       <= '0;
      prev_mech_r <= '0;
      prev_elec_r <= '0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // configuration writes, to be made only while idle by contract; the block does not enforce it
      if (cfg_we) begin
        unique case (cfg_index)
          eps_pkg::CFG_CPR:  cpr_r  <= cfg_wdata[eps_pkg::CPR_W-1:0];
          eps_pkg::CFG_PP:   pp_r   <= cfg_wdata[eps_pkg::PP_W-1:0];
          eps_pkg::CFG_RATE: rate_r <= cfg_wdata[eps_pkg::SR_W-1:0];
          default: ;
        endcase
      end

      // result taken downstream; in S_DONE the register is refilled instead
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            pp_sh_r <= pp_r;
            sr_sh_r <= rate_r;
            if (in_op == eps_pkg::OP_CLEAR) begin
              // clear position and count, result is all zero
              pos_r   <= '0;
              last_r  <= '0;
              q_r     <= '0;
              elec_r  <= '0;
              ms_r    <= '0;
              es_r    <= '0;
              state_r <= S_DONE;
            end else begin
              delta_r <= delta_in;
              last_r  <= in_counter_value;
              state_r <= S_POS;
            end
          end
        end
        S_POS: begin
          pos_r   <= pos_r + {{(eps_pkg::POS_W-eps_pkg::CNT_IN_W-1){delta_r[eps_pkg::CNT_IN_W]}},
                              delta_r};
          state_r <= S_ABS;
        end
        S_ABS: begin
          neg_r   <= pos_r[eps_pkg::POS_W-1];
          mag_r   <= pos_r[eps_pkg::POS_W-1] ? (~pos_r + eps_pkg::POS_W'(1)) : pos_r;
          rem_r   <= '0;
          seq_r   <= eps_pkg::SEQ_W'(eps_pkg::MOD_CYC - 1);
          state_r <= S_MOD;
        end
        S_MOD: begin
          // two position bits per cycle into the remainder
          rem_r <= st2.rem;
          mag_r <= {mag_r[eps_pkg::POS_W-3:0], 2'b00};
          seq_r <= seq_r - eps_pkg::SEQ_W'(1);
          if (seq_r == '0) begin
            state_r <= S_FIX;
          end
        end
        S_FIX: begin
          // floor modulo for a negative position
          if (neg_r && rem_r != '0) begin
            rem_r <= cpr_eff - rem_r;
          end
          q_r     <= '0;
          seq_r   <= eps_pkg::SEQ_W'(eps_pkg::DIV_CYC - 1);
          state_r <= S_DIV;
        end
        S_DIV: begin
          // two angle bits per cycle
          rem_r <= st2.rem;
          q_r   <= {q_r[eps_pkg::ANGLE_W-3:0], st1.q, st2.q};
          if (seq_r == '0) begin
            elec_r  <= '0;
            seq_r   <= eps_pkg::SEQ_W'(eps_pkg::PP_W - 1);
            state_r <= S_ELEC;
          end else begin
            seq_r <= seq_r - eps_pkg::SEQ_W'(1);
          end
        end
        S_ELEC: begin
          // angle times pole pairs, mod one turn, one pole pair bit a cycle
          elec_r  <= {elec_r[eps_pkg::ANGLE_W-2:0], 1'b0} +
                     (pp_sh_r[eps_pkg::PP_W-1] ? q_r : '0);
          pp_sh_r <= {pp_sh_r[eps_pkg::PP_W-2:0], 1'b0};
          if (seq_r == '0) begin
            ms_r    <= '0;
            es_r    <= '0;
            seq_r   <= eps_pkg::SEQ_W'(eps_pkg::SR_W - 1);
            state_r <= S_SPD;
          end else begin
            seq_r <= seq_r - eps_pkg::SEQ_W'(1);
          end
        end
        S_SPD: begin
          // both speeds, one rate bit a cycle
          ms_r    <= {ms_r[eps_pkg::SPEED_W-2:0], 1'b0} + add_mech;
          es_r    <= {es_r[eps_pkg::SPEED_W-2:0], 1'b0} + add_elec;
          sr_sh_r <= {sr_sh_r[eps_pkg::SR_W-2:0], 1'b0};
          seq_r   <= seq_r - eps_pkg::SEQ_W'(1);
          if (seq_r == '0) begin
            prev_mech_r <= q_r;
            prev_elec_r <= elec_r;
            have_r      <= 1'b1;
            state_r     <= S_DONE;
          end
        end
        S_DONE: begin
          // hand over once the output register is free
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_pos_r   <= pos_r;
            out_mech_r  <= q_r;
            out_elec_r  <= elec_r;
            out_ms_r    <= ms_r;
            out_es_r    <= es_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_position = out_pos_r;
  assign out_mech_ang = out_mech_r;
  assign out_elec_ang = out_elec_r;
  assign out_mech_spd = out_ms_r;
  assign out_elec_spd = out_es_r;

endmodule
